### src/tncm_pkg.sv
// shared constants, types and mode codes of the table nco complex modulator
// no dependencies
`timescale 1ns / 1ps

package tncm_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_W     = 32;
    localparam int IDX_W       = 10;
    localparam int SMP_W       = 16;
    localparam int ENTRY_W     = 2 * SAMPLE_BITS;

    localparam logic [PHASE_W-1:0] HALF_ENTRY = PHASE_W'(64'd1 << (31 - TABLE_BITS));

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_SET  = 2'd1,
        MODE_GEN  = 2'd2
    } tncm_mode_t;

    typedef struct packed {
        logic               set;
        logic               step;
        logic [PHASE_W-1:0] start_phase;
    } tncm_phase_cmd_t;

endpackage

### src/tncm_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tncm_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/tncm_phase.sv
// phase accumulator and phase increment register
// depends on tncm_pkg
`timescale 1ns / 1ps

module tncm_phase (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tncm_pkg::PHASE_W-1:0]        cfg_data,
    input  tncm_pkg::tncm_phase_cmd_t           cmd,
    output logic [tncm_pkg::TABLE_BITS-1:0]     index,
    output logic [tncm_pkg::PHASE_W-1:0]        phase_after
);

    import tncm_pkg::*;

    logic [PHASE_W-1:0] incr_reg;
    logic [PHASE_W-1:0] acc_reg;
    logic [PHASE_W-1:0] acc_step;
    logic [PHASE_W-1:0] acc_next;

    assign acc_step = acc_reg + incr_reg;

    always_comb begin
        acc_next = acc_reg;
        if (cmd.set) begin
            acc_next = cmd.start_phase + HALF_ENTRY;
        end else if (cmd.step) begin
            acc_next = acc_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            incr_reg <= '0;
            acc_reg  <= HALF_ENTRY;
        end else begin
            if (cfg_we) begin
                incr_reg <= cfg_data;
            end
            acc_reg <= acc_next;
        end
    end

    assign index       = acc_reg[PHASE_W-1 -: TABLE_BITS];
    assign phase_after = acc_step - HALF_ENTRY;

endmodule

### src/tncm_scale.sv
// one lane: registered product, then round half up and saturate
// depends on tncm_pkg
`timescale 1ns / 1ps

module tncm_scale (
    input  logic                                   aclk,
    input  logic                                   mul_en,
    input  logic                                   out_en,
    input  logic signed [tncm_pkg::SAMPLE_BITS-1:0] amp,
    input  logic signed [tncm_pkg::SAMPLE_BITS-1:0] coef,
    output logic signed [tncm_pkg::SAMPLE_BITS-1:0] res
);

    import tncm_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam logic signed [PROD_W:0] RND    = (PROD_W + 1)'(64'd1 << (SAMPLE_BITS - 2));
    localparam logic signed [PROD_W:0] SAT_HI =
        (PROD_W + 1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [PROD_W:0] SAT_LO = -SAT_HI - (PROD_W + 1)'(1);

    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W:0]        sum_s;
    logic signed [PROD_W:0]        q_s;
    logic signed [SAMPLE_BITS-1:0] res_next;
    logic signed [SAMPLE_BITS-1:0] res_reg;

    always_comb begin
        sum_s = {prod_reg[PROD_W-1], prod_reg} + RND;
        q_s   = sum_s >>> (SAMPLE_BITS - 1);
        if (q_s > SAT_HI) begin
            res_next = SAT_HI[SAMPLE_BITS-1:0];
        end else if (q_s < SAT_LO) begin
            res_next = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            res_next = q_s[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= amp * coef;
        end
        if (out_en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### src/table_nco_complex_modulator_unit.sv
// top level of the table nco complex modulator
// depends on tncm_pkg, tncm_ram, tncm_phase, tncm_scale
`timescale 1ns / 1ps

// Table-driven oscillator with complex output. The phase accumulator's top bits
// address a 1024-entry cosine/sine table in block memory; a generate item
// scales the entry by its amplitude (Q1.15, rounded half up, saturated) and
// advances the phase by the increment written on the cfg port. Load items
// write one table entry and set-phase items load the accumulator; neither
// gives a result, nor does mode 3. One item is accepted per cycle while s_ready
// is high; s_ready drops only when every stage holds an item and m_ready is
// low. The table read is registered at the edge that accepts its item, then
// the products, then the rounded result in the output register. A load followed
// at once by a generate of the same entry reads the new value. Table entries
// never loaded read as arbitrary data.

module table_nco_complex_modulator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tncm_pkg::PHASE_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic [tncm_pkg::IDX_W-1:0]          s_entry_index,
    input  logic signed [tncm_pkg::SMP_W-1:0]   s_entry_cos,
    input  logic signed [tncm_pkg::SMP_W-1:0]   s_entry_sin,
    input  logic [tncm_pkg::PHASE_W-1:0]        s_start_phase,
    input  logic signed [tncm_pkg::SMP_W-1:0]   s_amplitude,
    input  logic                                s_last_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tncm_pkg::SMP_W-1:0]   m_out_real,
    output logic signed [tncm_pkg::SMP_W-1:0]   m_out_imag,
    output logic [tncm_pkg::PHASE_W-1:0]        m_phase_now,
    output logic                                m_last_out
);

    import tncm_pkg::*;

    logic en_out;
    logic en2;
    logic en1;
    logic take;
    logic take_gen;
    logic take_load;

    tncm_phase_cmd_t phase_cmd;
    logic [TABLE_BITS-1:0] rd_index;
    logic [PHASE_W-1:0]    phase_after;
    logic [ENTRY_W-1:0]    wr_entry;
    logic [ENTRY_W-1:0]    rd_entry;

    logic                          v1_reg;
    logic                          last1_reg;
    logic [PHASE_W-1:0]            phase1_reg;
    logic signed [SAMPLE_BITS-1:0] amp1_reg;

    logic               v2_reg;
    logic               last2_reg;
    logic [PHASE_W-1:0] phase2_reg;

    logic               m_valid_reg;
    logic               last_out_reg;
    logic [PHASE_W-1:0] phase_out_reg;

    logic signed [SAMPLE_BITS-1:0] res_re;
    logic signed [SAMPLE_BITS-1:0] res_im;

    assign en_out = !m_valid_reg || m_ready;
    assign en2    = !v2_reg || en_out;
    assign en1    = !v1_reg || en2;

    assign s_ready   = en1;
    assign cfg_ready = 1'b1;

    assign take      = s_valid && en1;
    assign take_gen  = take && (s_mode == MODE_GEN);
    assign take_load = take && (s_mode == MODE_LOAD);

    always_comb begin
        phase_cmd.set         = take && (s_mode == MODE_SET);
        phase_cmd.step        = take_gen;
        phase_cmd.start_phase = s_start_phase;
    end

    assign wr_entry = {SAMPLE_BITS'(s_entry_cos), SAMPLE_BITS'(s_entry_sin)};

    tncm_phase u_phase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .cmd         (phase_cmd),
        .index       (rd_index),
        .phase_after (phase_after)
    );

    tncm_ram #(
        .ADDR_W (TABLE_BITS),
        .DATA_W (ENTRY_W)
    ) u_table (
        .aclk  (aclk),
        .we    (take_load),
        .waddr (TABLE_BITS'(s_entry_index)),
        .wdata (wr_entry),
        .re    (take_gen),
        .raddr (rd_index),
        .rdata (rd_entry)
    );

    tncm_scale u_scale_re (
        .aclk   (aclk),
        .mul_en (en2 && v1_reg),
        .out_en (en_out && v2_reg),
        .amp    (amp1_reg),
        .coef   (rd_entry[ENTRY_W-1 -: SAMPLE_BITS]),
        .res    (res_re)
    );

    tncm_scale u_scale_im (
        .aclk   (aclk),
        .mul_en (en2 && v1_reg),
        .out_en (en_out && v2_reg),
        .amp    (amp1_reg),
        .coef   (rd_entry[SAMPLE_BITS-1:0]),
        .res    (res_im)
    );

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= take_gen;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en_out) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (take_gen) begin
            last1_reg  <= s_last_in;
            phase1_reg <= phase_after;
            amp1_reg   <= SAMPLE_BITS'(s_amplitude);
        end
        if (en2 && v1_reg) begin
            last2_reg  <= last1_reg;
            phase2_reg <= phase1_reg;
        end
        if (en_out && v2_reg) begin
            last_out_reg  <= last2_reg;
            phase_out_reg <= phase2_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_real  = SMP_W'(res_re);
    assign m_out_imag  = SMP_W'(res_im);
    assign m_phase_now = phase_out_reg;
    assign m_last_out  = last_out_reg;

`ifndef SYNTH
    a_gen_enters_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        take_gen |=> v1_reg)
        else $error("generate item did not enter the read stage");

    a_stage2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !en_out) |=> (v2_reg && $stable(phase2_reg)))
        else $error("stalled product stage lost its item");

    a_result_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v2_reg))
        else $error("result appeared without a product stage item");

    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while the pipeline is full and stalled");
`endif

endmodule
